// ===== src/ihrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihrp_pkg
// Shared types, codes and helpers of the Intel HEX record parser.
// ----------------------------------------------------------------------------
package ihrp_pkg;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic       KIND_DATA    = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM   = 2'd1;
    localparam logic [1:0] STATUS_BAD_CHAR  = 2'd2;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

    localparam logic [7:0] TYPE_DATA    = 8'd0;
    localparam logic [7:0] TYPE_SEGMENT = 8'd2;
    localparam logic [7:0] TYPE_LINEAR  = 8'd4;

    localparam int SEGMENT_SHIFT = 12;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic [7:0]  record_type;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
    } char_beat_t;

    typedef struct packed {
        logic    valid;
        result_t result;
    } result_beat_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            d.value = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            d.value = c[3:0] + 4'd9;
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== src/ihrp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihrp_char_if / ihrp_result_if
// Valid/ready channels for the character stream and the result stream.
// ----------------------------------------------------------------------------
interface ihrp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface ihrp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  record_type;
    logic [1:0]  status;

    modport source (output valid, output kind, output address, output data_byte,
                    output record_type, output status, input ready);
    modport sink   (input valid, input kind, input address, input data_byte,
                    input record_type, input status, output ready);
endinterface

// ===== src/ihrp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihrp_in_stage
// Input register for one character beat.
// ----------------------------------------------------------------------------
module ihrp_in_stage
    import ihrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_code,
    output logic       in_ready,
    input  logic       take,
    output char_beat_t beat
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] code_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            code_reg <= in_code;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.code  = code_reg;

endmodule

// ===== src/ihrp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihrp_core
// Record state machine: decodes one character per beat, emits data bytes
// and record verdicts.
// ----------------------------------------------------------------------------
module ihrp_core
    import ihrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  char_beat_t   beat,
    input  logic         take,
    output result_beat_t res
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_COUNT  = 3'd1;
    localparam logic [2:0] PH_OFFSET = 3'd2;
    localparam logic [2:0] PH_TYPE   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CHECK  = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_SKIP   = 3'd7;

    logic [2:0]  phase_reg,    phase_next;
    logic        held_reg,     held_next;
    logic [3:0]  nibble_reg,   nibble_next;
    logic [7:0]  count_reg,    count_next;
    logic [15:0] offset_reg,   offset_next;
    logic [7:0]  type_reg,     type_next;
    logic [7:0]  index_reg,    index_next;
    logic [7:0]  sum_reg,      sum_next;
    logic [15:0] page_reg,     page_next;
    logic [15:0] pending_reg,  pending_next;

    logic        in_record;
    hex_digit_t  digit;
    logic [7:0]  byte_val;
    logic [7:0]  index_inc;
    logic [31:0] base;

    assign in_record = (phase_reg inside {[PH_COUNT:PH_CHECK]});
    assign digit     = hex_decode(beat.code);
    assign byte_val  = {nibble_reg, digit.value};
    assign index_inc = index_reg + 8'd1;
    assign base      = {page_reg, offset_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        held_next    = held_reg;
        nibble_next  = nibble_reg;
        count_next   = count_reg;
        offset_next  = offset_reg;
        type_next    = type_reg;
        index_next   = index_reg;
        sum_next     = sum_reg;
        page_next    = page_reg;
        pending_next = pending_reg;

        res.valid              = 1'b0;
        res.result.kind        = KIND_VERDICT;
        res.result.address     = base;
        res.result.data_byte   = 8'd0;
        res.result.record_type = type_reg;
        res.result.status      = STATUS_OK;

        if (beat.code == CHAR_COLON)
        begin
            res.valid         = in_record;
            res.result.status = STATUS_TRUNCATED;
            phase_next   = PH_COUNT;
            held_next    = 1'b0;
            nibble_next  = 4'd0;
            count_next   = 8'd0;
            offset_next  = 16'd0;
            type_next    = 8'd0;
            index_next   = 8'd0;
            sum_next     = 8'd0;
            pending_next = 16'd0;
        end
        else if (beat.code == CHAR_CR || beat.code == CHAR_LF)
        begin
            res.valid         = in_record;
            res.result.status = STATUS_TRUNCATED;
            phase_next = PH_IDLE;
            held_next  = 1'b0;
        end
        else if (in_record)
        begin
            if (!digit.ok)
            begin
                res.valid         = 1'b1;
                res.result.status = STATUS_BAD_CHAR;
                phase_next = PH_SKIP;
                held_next  = 1'b0;
            end
            else if (!held_reg)
            begin
                nibble_next = digit.value;
                held_next   = 1'b1;
            end
            else
            begin
                held_next = 1'b0;
                sum_next  = sum_reg + byte_val;
                case (phase_reg)
                    PH_COUNT:
                    begin
                        count_next = byte_val;
                        index_next = 8'd0;
                        phase_next = PH_OFFSET;
                    end
                    PH_OFFSET:
                    begin
                        offset_next = {offset_reg[7:0], byte_val};
                        if (index_inc >= 8'd2)
                        begin
                            index_next = 8'd0;
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            index_next = index_inc;
                        end
                    end
                    PH_TYPE:
                    begin
                        type_next  = byte_val;
                        phase_next = (count_reg == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        if (index_reg == 8'd0)
                        begin
                            pending_next = {byte_val, 8'd0};
                        end
                        else if (index_reg == 8'd1)
                        begin
                            pending_next = {pending_reg[15:8], byte_val};
                        end
                        if (type_reg == TYPE_DATA)
                        begin
                            res.valid            = 1'b1;
                            res.result.kind      = KIND_DATA;
                            res.result.address   = base + {24'd0, index_reg};
                            res.result.data_byte = byte_val;
                        end
                        index_next = index_inc;
                        if (index_inc >= count_reg)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        res.valid         = 1'b1;
                        res.result.status = (sum_next == 8'd0) ? STATUS_OK : STATUS_BAD_SUM;
                        if (sum_next == 8'd0)
                        begin
                            if (type_reg == TYPE_SEGMENT)
                            begin
                                page_next = pending_reg >> SEGMENT_SHIFT;
                            end
                            else if (type_reg == TYPE_LINEAR)
                            begin
                                page_next = pending_reg;
                            end
                        end
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            held_reg    <= 1'b0;
            nibble_reg  <= 4'd0;
            count_reg   <= 8'd0;
            offset_reg  <= 16'd0;
            type_reg    <= 8'd0;
            index_reg   <= 8'd0;
            sum_reg     <= 8'd0;
            page_reg    <= 16'd0;
            pending_reg <= 16'd0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            nibble_reg  <= nibble_next;
            count_reg   <= count_next;
            offset_reg  <= offset_next;
            type_reg    <= type_next;
            index_reg   <= index_next;
            sum_reg     <= sum_next;
            page_reg    <= page_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== src/ihrp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihrp_out_stage
// Result register holding one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module ihrp_out_stage
    import ihrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  result_beat_t res,
    input  logic         out_ready,
    output logic         out_valid,
    output result_t      out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res.valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            result_reg <= res.result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== src/intel_hex_record_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_parser_top
// Intel HEX record parser: one ASCII character per beat in, tentative data
// bytes and record verdicts out.
//
//   channel   dir   payload                                          beats
//   char_in   in    char_code[7:0]                                   1 per char
//   rec_out   out   kind, address[31:0], data_byte[7:0],             0 or 1
//                   record_type[7:0], status[1:0]                    per char
//
// one character per cycle sustained while the sink does not stall; a result
// is valid once its character passes the input, then the result register
// the record state advances when the held character moves into the result
// register, which happens whenever that register is empty or being drained
// a stalled sink holds one result and one character, then deasserts ready
// reset clears phase, counters, sum and page at once
// ----------------------------------------------------------------------------
module intel_hex_record_parser_top
    import ihrp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ihrp_char_if.sink     char_in,
    ihrp_result_if.source rec_out
);

    char_beat_t   beat;
    result_beat_t res;
    result_t      out_result;
    logic         out_valid;
    logic         take;

    assign take = beat.valid && (!out_valid || rec_out.ready);

    ihrp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_code  (char_in.char_code),
        .in_ready (char_in.ready),
        .take     (take),
        .beat     (beat)
    );

    ihrp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .take  (take),
        .res   (res)
    );

    ihrp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .res        (res),
        .out_ready  (rec_out.ready),
        .out_valid  (out_valid),
        .out_result (out_result)
    );

    assign rec_out.valid       = out_valid;
    assign rec_out.kind        = out_result.kind;
    assign rec_out.address     = out_result.address;
    assign rec_out.data_byte   = out_result.data_byte;
    assign rec_out.record_type = out_result.record_type;
    assign rec_out.status      = out_result.status;

endmodule
